// ----- hdl/sie_pkg.sv -----
// sie_pkg: shared types for the set intersection engine.
// Holds the action codes and the command/status structs between top and table.
// No dependencies.
`timescale 1ns / 1ps

package sie_pkg;

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_LOAD  = 2'd1,
      ACT_PROBE = 2'd2
   } action_type;

   localparam int VALUE_W = 32;

   // Command into the membership table, already qualified by stage advance.
   typedef struct packed {
      logic clear;
      logic load;
      logic probe;
   } table_cmd_type;

   // Lookup status of the current key against the table contents.
   typedef struct packed {
      logic hit;
      logic hit_reported;
      logic full;
   } table_stat_type;

endpackage

// ----- hdl/sie_match_table.sv -----
// sie_match_table: membership table with a parallel compare over all entries.
// Entries fill in order, so the fill count tells which entries are valid.
// Depends on sie_pkg.
`timescale 1ns / 1ps

module sie_match_table #(
   parameter int CAPACITY = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sie_pkg::table_cmd_type cmd_in,
   input  logic [31:0]           key_in,
   output sie_pkg::table_stat_type stat_out
);
   import sie_pkg::*;

   localparam int COUNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic [VALUE_W-1:0] value_ff [CAPACITY];
   logic [CAPACITY-1:0] reported_ff, reported_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [CAPACITY-1:0] match;
   logic                full;
   logic                hit;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_idx;

   // Compare every filled entry against the key; values are unique in the table.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
      assign match[i] = (count_ff > COUNT_W'(i)) && (value_ff[i] == key_in);
   end

   assign hit    = |match;
   assign full   = (count_ff >= COUNT_W'(CAPACITY));
   assign wr_en  = cmd_in.load && !hit && !full;
   assign wr_idx = count_ff[IDX_W-1:0];

   assign stat_out.hit          = hit;
   assign stat_out.hit_reported = |(match & reported_ff);
   assign stat_out.full         = full;

   always_comb begin
      count_in    = count_ff;
      reported_in = reported_ff;
      if (cmd_in.clear) begin
         count_in    = '0;
         reported_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (cmd_in.probe) begin
         reported_in = reported_ff | match;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         reported_ff <= '0;
      end else begin
         count_ff    <= count_in;
         reported_ff <= reported_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         value_ff[wr_idx] <= key_in;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("fill count above capacity");

   a_unique_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match))
      else $error("key matches more than one entry");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd_in.clear |=> (count_ff == '0) && (reported_ff == '0))
      else $error("clear did not empty the table");
`endif

endmodule

// ----- hdl/set_intersection_engine.sv -----
// set_intersection_engine: top level of the streaming set intersection engine.
// Holds the input stage, action decode and result register around the table.
// Depends on sie_pkg and sie_match_table.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------
//   req     | in        | req_valid/req_stall | req_action[1:0], req_value[31:0]
//   rsp     | out       | rsp_valid/rsp_stall | rsp_common_value[31:0], rsp_status
//
// One item per cycle sustained while the result is not stalled: an accepted item
// waits in the input stage, where the parallel compare over all entries and the
// table update happen, and its result (if any) then goes to the result register.
// Reset is synchronous and empties the table at once; no clearing pass.
// A stalled result holds the input stage, which then stalls req; items with no
// result also wait behind a stalled result so order stays simple.
`timescale 1ns / 1ps

module set_intersection_engine #(
   parameter int CAPACITY = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_common_value,
   output logic               rsp_status
);
   import sie_pkg::*;

   // Input stage
   logic               stage_valid_ff;
   logic [1:0]         stage_action_ff;
   logic [VALUE_W-1:0] stage_value_ff;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_status_ff, rsp_status_in;

   logic           out_free;
   logic           advance;
   logic           produce;
   table_cmd_type  cmd;
   table_stat_type stat;

   // The result register is free when empty or being taken this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = stage_valid_ff && out_free;
   assign req_stall = stage_valid_ff && !out_free;

   // Decode the staged action; only an advancing item touches the table.
   always_comb begin
      cmd = '0;
      unique case (action_type'(stage_action_ff))
         ACT_CLEAR: cmd.clear = advance;
         ACT_LOAD:  cmd.load  = advance;
         ACT_PROBE: cmd.probe = advance;
         default:   cmd       = '0;   // unused code: drop silently
      endcase
   end

   sie_match_table #(
      .CAPACITY(CAPACITY)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .cmd_in  (cmd),
      .key_in  (stage_value_ff),
      .stat_out(stat)
   );

   // Form the result: a new load into a full table reports an error with zero
   // value; a first hit on probe reports the value.
   always_comb begin
      produce       = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      priority if (cmd.load && !stat.hit && stat.full) begin
         produce       = 1'b1;
         rsp_value_in  = '0;
         rsp_status_in = 1'b1;
      end else if (cmd.probe && stat.hit && !stat.hit_reported) begin
         produce       = 1'b1;
         rsp_value_in  = stage_value_ff;
         rsp_status_in = 1'b0;
      end else begin
         produce = 1'b0;
      end
      rsp_valid_in = out_free ? produce : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (!req_stall) begin
            stage_valid_ff <= req_valid;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: load the stage on accept, the result on produce.
   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         stage_action_ff <= req_action;
         stage_value_ff  <= req_value;
      end
      if (produce) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_common_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

`ifndef SYNTH
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_common_value == '0))
      else $error("error result carries a nonzero value");

   a_result_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(advance))
      else $error("result appeared without an advancing item");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && rsp_valid && rsp_stall)
      |=> stage_valid_ff && $stable(stage_value_ff) && $stable(stage_action_ff))
      else $error("input stage moved under a stalled result");
`endif

endmodule

// ----- bench/set_intersection_engine_tb.sv -----
// set_intersection_engine_tb: self-checking testbench for the set intersection engine.
// Runs directed and random clear/load/probe items under random idling and checks results.
// Depends on sie_pkg and set_intersection_engine.
`timescale 1ns / 1ps

module set_intersection_engine_tb;
   import sie_pkg::*;

   localparam int          CAPACITY    = 64;
   localparam int          ITEM_TARGET = 1150;
   localparam int          QUIET_ITEMS = 150;    // no idling over the last items
   localparam int          IDLE_LIMIT  = 2000;   // cycles with no handshake at all
   localparam int          SETTLE      = 4;      // settle time after the final drain, with margin
   localparam logic [1:0]  ACT_UNUSED  = 2'd3;   // undefined code, must be ignored
   localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VALUE_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      logic signed [31:0] common_value;
      logic               status;
   } match_result_type;

   // Membership table mirror plus the queue of results still owed by the block.
   class intersect_scoreboard;
      logic signed [31:0] slot_value [CAPACITY];
      bit                 slot_valid [CAPACITY];
      bit                 slot_reported [CAPACITY];
      int unsigned        fill_count;
      match_result_type   expected_q[$];
      int unsigned        fail_count;
      int unsigned        match_count;
      int unsigned        full_count;

      function new();
         foreach (slot_value[i]) slot_value[i] = '0;
         clear_table();
         fail_count  = 0;
         match_count = 0;
         full_count  = 0;
      endfunction

      function void clear_table();
         foreach (slot_valid[i]) begin
            slot_valid[i]    = 1'b0;
            slot_reported[i] = 1'b0;
         end
         fill_count = 0;
      endfunction

      function int find_slot(logic signed [31:0] v);
         foreach (slot_valid[i])
            if (slot_valid[i] && slot_value[i] == v) return i;
         return -1;
      endfunction

      // Update the mirror for an accepted item and queue the result it owes.
      function void note_item(logic [1:0] act, logic signed [31:0] v);
         int               hit;
         match_result_type res;
         case (act)
            ACT_CLEAR: begin
               clear_table();
            end
            ACT_LOAD: begin
               hit = find_slot(v);
               if (hit < 0) begin
                  if (fill_count >= CAPACITY) begin
                     res.common_value = '0;
                     res.status       = 1'b1;
                     expected_q       = {expected_q, res};
                  end else begin
                     slot_value[fill_count]    = v;
                     slot_valid[fill_count]    = 1'b1;
                     slot_reported[fill_count] = 1'b0;
                     fill_count++;
                  end
               end
            end
            ACT_PROBE: begin
               hit = find_slot(v);
               if (hit >= 0 && !slot_reported[hit]) begin
                  slot_reported[hit] = 1'b1;
                  res.common_value   = v;
                  res.status         = 1'b0;
                  expected_q         = {expected_q, res};
               end
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic signed [31:0] got_value, logic got_status);
         match_result_type want;
         if (expected_q.size() == 0) begin
            $error("unexpected result: common_value %0d, status %0d", got_value, got_status);
            fail_count++;
            return;
         end
         want = expected_q.pop_front();
         if (got_value !== want.common_value) begin
            $error("common_value: expected %0d, got %0d", want.common_value, got_value);
            fail_count++;
         end
         if (got_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got_status);
            fail_count++;
         end
         if (want.status) full_count++;
         else             match_count++;
      endfunction
   endclass

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_stall;
   logic [1:0]         req_action       = ACT_CLEAR;
   logic signed [31:0] req_value        = '0;
   logic               rsp_valid;
   logic               rsp_stall        = 1'b0;
   logic signed [31:0] rsp_common_value;
   logic               rsp_status;

   intersect_scoreboard sb = new();

   int  item_count  = 0;
   int  seq_count   = 0;
   int  idle_cycles = 0;
   int  hold_left   = 0;   // remaining cycles of the current result stall burst
   int  calm_left   = 0;   // remaining cycles of a stretch with no idling anywhere
   bit  quiet       = 1'b0;

   set_intersection_engine #(.CAPACITY(CAPACITY)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_common_value (rsp_common_value),
      .rsp_status       (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver side: stall in random bursts, skip them during calm stretches
   // and in the quiet tail of the run.
   always @(negedge clock) begin
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(50, 150);
      if (hold_left == 0 && !quiet && calm_left == 0 && $urandom_range(0, 7) == 0)
         hold_left = $urandom_range(1, 8);
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Check every accepted result against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_common_value, rsp_status);
   end

   // Watchdog: end the run if no handshake happens on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no handshake for %0d cycles, %0d results owed",
                  IDLE_LIMIT, sb.expected_q.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Mostly random values, with the extremes and a small range mixed in so
   // that loads and probes collide often.
   function automatic logic signed [31:0] rand_value();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 3))
               0:       return VALUE_MIN;
               1:       return VALUE_MAX;
               2:       return '0;
               default: return -32'sd1;
            endcase
         end
         1, 2:    return $signed($urandom_range(0, 31)) - 32'sd16;
         default: return $urandom;
      endcase
   endfunction

   // Present one item, hold it until accepted, then note it in the scoreboard.
   // Valid stays high afterwards so back-to-back items need no extra cycle.
   task automatic send_item(input logic [1:0] act, input logic signed [31:0] v);
      int burst;
      if (!quiet && calm_left == 0 && $urandom_range(0, 5) == 0) begin
         burst = $urandom_range(1, 8);
         repeat (burst) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_valid  <= 1'b1;
      req_action <= act;
      req_value  <= v;
      do @(posedge clock); while (req_stall);
      sb.note_item(act, v);
      if (act != ACT_UNUSED) item_count++;
      if (item_count >= ITEM_TARGET - QUIET_ITEMS) quiet = 1'b1;
   endtask

   // Drop valid and hold the sender until every owed result has come out.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   // One well-formed set pair: usually a clear, then interleaved loads of a
   // planned first set and probes drawn mostly from that same set. Probes may
   // name values that are loaded only later. Some noise is mixed in.
   task automatic run_sequence(input int n_load, input int n_probe);
      logic signed [31:0] planned[$];
      logic signed [31:0] v;
      int                 loads_done;
      int                 probes_done;
      int                 pick;
      if ($urandom_range(0, 9) != 0) send_item(ACT_CLEAR, rand_value());
      for (int i = 0; i < n_load; i++) begin
         v       = rand_value();
         planned = {planned, v};
      end
      loads_done  = 0;
      probes_done = 0;
      while (loads_done < n_load || probes_done < n_probe) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            send_item(ACT_UNUSED, rand_value());
         end else if (pick < 6) begin
            send_item(ACT_LOAD, rand_value());
         end else if (probes_done >= n_probe || (loads_done < n_load && pick < 55)) begin
            // reload an earlier value now and then to hit the duplicate path
            if (loads_done > 0 && $urandom_range(0, 6) == 0) begin
               v = planned[$urandom_range(0, loads_done - 1)];
            end else begin
               v = planned[loads_done];
               loads_done++;
            end
            send_item(ACT_LOAD, v);
         end else begin
            if ($urandom_range(0, 5) == 0) v = rand_value();
            else                           v = planned[$urandom_range(0, n_load - 1)];
            send_item(ACT_PROBE, v);
            probes_done++;
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty table, extremes, duplicates, repeats, unused code,
      // load after probe, and a clear in between.
      send_item(ACT_CLEAR, '0);
      send_item(ACT_PROBE, 32'sd5);            // miss on an empty table
      send_item(ACT_LOAD,  VALUE_MIN);
      send_item(ACT_LOAD,  VALUE_MAX);
      send_item(ACT_LOAD,  '0);
      send_item(ACT_LOAD,  -32'sd1);
      send_item(ACT_LOAD,  -32'sd1);           // duplicate, ignored
      send_item(ACT_UNUSED, VALUE_MAX);        // unused code, ignored
      send_item(ACT_PROBE, VALUE_MAX);
      send_item(ACT_PROBE, VALUE_MAX);         // already reported
      send_item(ACT_PROBE, VALUE_MIN);
      send_item(ACT_PROBE, '0);
      send_item(ACT_PROBE, -32'sd1);
      send_item(ACT_PROBE, 32'sh1234_5678);    // not loaded yet
      send_item(ACT_LOAD,  32'sh1234_5678);
      send_item(ACT_PROBE, 32'sh1234_5678);    // reported now
      send_item(ACT_LOAD,  '0);                // duplicate keeps its reported mark
      send_item(ACT_PROBE, '0);
      send_item(ACT_CLEAR, VALUE_MAX);
      send_item(ACT_PROBE, -32'sd1);           // gone after the clear
      send_item(ACT_LOAD,  -32'sd1);
      send_item(ACT_PROBE, -32'sd1);
      drain_results();

      // Random set pairs; the first one and some later ones load about as many values as the table holds, or more.
      while (item_count < ITEM_TARGET) begin
         if (seq_count == 0 || $urandom_range(0, 5) == 0)
            run_sequence($urandom_range(CAPACITY - 4, CAPACITY + 8), $urandom_range(1, 30));
         else
            run_sequence($urandom_range(1, 20), $urandom_range(1, 30));
         seq_count++;
         if (seq_count == 10) drain_results();
      end

      drain_results();
      repeat (SETTLE) @(posedge clock);

      $display("Covered %0d items in %0d set pairs: %0d common values, %0d full-table drops.",
               item_count, seq_count, sb.match_count, sb.full_count);
      if (sb.fail_count == 0 && sb.expected_q.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
